### src/gcbd_pkg.sv
package gcbd_pkg;

    // Grapheme break classes
    localparam logic [3:0] C_OTHER   = 4'd0;
    localparam logic [3:0] C_CR      = 4'd1;
    localparam logic [3:0] C_LF      = 4'd2;
    localparam logic [3:0] C_CONTROL = 4'd3;
    localparam logic [3:0] C_L       = 4'd4;
    localparam logic [3:0] C_V       = 4'd5;
    localparam logic [3:0] C_T       = 4'd6;
    localparam logic [3:0] C_LV      = 4'd7;
    localparam logic [3:0] C_LVT     = 4'd8;
    localparam logic [3:0] C_EXTEND  = 4'd9;
    localparam logic [3:0] C_ZWJ     = 4'd10;
    localparam logic [3:0] C_SPACING = 4'd11;
    localparam logic [3:0] C_PREPEND = 4'd12;
    localparam logic [3:0] C_RI      = 4'd13;

    // Indic conjunct classes
    localparam logic [1:0] K_NONE      = 2'd0;
    localparam logic [1:0] K_CONSONANT = 2'd1;
    localparam logic [1:0] K_LINKER    = 2'd2;
    localparam logic [1:0] K_EXTEND    = 2'd3;

    // One codepoint's properties
    typedef struct packed {
        logic [3:0] gcb_class;
        logic [1:0] conjunct_class;
        logic       is_pictographic;
        logic       text_start;
    } t_item;

    // Segmenter state carried between codepoints
    typedef struct packed {
        logic [3:0] previous_class;
        logic       indicator_run_odd;
        logic       pict_chain_open;
        logic       joiner_after_pict;
        logic       consonant_seen;
        logic       linker_seen;
    } t_state;

    localparam t_state STATE_RESET = '{
        previous_class:    C_OTHER,
        indicator_run_odd: 1'b0,
        pict_chain_open:   1'b0,
        joiner_after_pict: 1'b0,
        consonant_seen:    1'b0,
        linker_seen:       1'b0
    };

endpackage

### src/gcbd_rules.sv
module gcbd_rules (
    input  gcbd_pkg::t_item  i_item,
    input  gcbd_pkg::t_state i_state,
    output logic             o_break,
    output gcbd_pkg::t_state o_state
);
    import gcbd_pkg::*;

    logic [3:0] c;
    logic [3:0] p;
    logic       rule_break;
    logic       brk;

    // Unused class codes behave as Other
    assign c = (i_item.gcb_class > C_RI) ? C_OTHER : i_item.gcb_class;
    assign p = i_state.previous_class;

    // Boundary rules, highest priority first
    always_comb begin
        if (p == C_CR && c == C_LF) begin
            rule_break = 1'b0;
        end else if (p == C_CONTROL || p == C_CR || p == C_LF) begin
            rule_break = 1'b1;
        end else if (c == C_CONTROL || c == C_CR || c == C_LF) begin
            rule_break = 1'b1;
        end else if (p == C_L && (c == C_L || c == C_V || c == C_LV || c == C_LVT)) begin
            rule_break = 1'b0;
        end else if ((p == C_LV || p == C_V) && (c == C_V || c == C_T)) begin
            rule_break = 1'b0;
        end else if ((p == C_LVT || p == C_T) && c == C_T) begin
            rule_break = 1'b0;
        end else if (c == C_EXTEND || c == C_ZWJ || c == C_SPACING) begin
            rule_break = 1'b0;
        end else if (p == C_PREPEND) begin
            rule_break = 1'b0;
        end else if (i_state.consonant_seen && i_state.linker_seen
                     && i_item.conjunct_class == K_CONSONANT) begin
            rule_break = 1'b0;
        end else if (i_state.joiner_after_pict && i_item.is_pictographic) begin
            rule_break = 1'b0;
        end else if (p == C_RI && c == C_RI) begin
            rule_break = !i_state.indicator_run_odd;
        end else begin
            rule_break = 1'b1;
        end
    end

    assign brk     = i_item.text_start || rule_break;
    assign o_break = brk;

    // Chain flags: reseed on a break, advance otherwise
    always_comb begin
        o_state                = i_state;
        o_state.previous_class = c;
        if (brk) begin
            o_state.indicator_run_odd = (c == C_RI);
            o_state.pict_chain_open   = i_item.is_pictographic;
            o_state.joiner_after_pict = 1'b0;
            o_state.consonant_seen    = (i_item.conjunct_class == K_CONSONANT);
            o_state.linker_seen       = 1'b0;
        end else begin
            o_state.indicator_run_odd = (c == C_RI) ? !i_state.indicator_run_odd : 1'b0;

            // emoji chain: pict Extend* ZWJ pict
            if (i_item.is_pictographic) begin
                o_state.pict_chain_open   = 1'b1;
                o_state.joiner_after_pict = 1'b0;
            end else if (c == C_EXTEND && i_state.pict_chain_open
                         && !i_state.joiner_after_pict) begin
                o_state.pict_chain_open   = 1'b1;
            end else if (c == C_ZWJ && i_state.pict_chain_open
                         && !i_state.joiner_after_pict) begin
                o_state.joiner_after_pict = 1'b1;
            end else begin
                o_state.pict_chain_open   = 1'b0;
                o_state.joiner_after_pict = 1'b0;
            end

            // conjunct: consonant (linker|extend)* consonant, with at least one linker
            if (i_item.conjunct_class == K_CONSONANT) begin
                o_state.consonant_seen = 1'b1;
                o_state.linker_seen    = 1'b0;
            end else if (i_state.consonant_seen && i_item.conjunct_class == K_LINKER) begin
                o_state.linker_seen    = 1'b1;
            end else if (i_state.consonant_seen && i_item.conjunct_class == K_EXTEND) begin
                o_state.linker_seen    = i_state.linker_seen;
            end else begin
                o_state.consonant_seen = 1'b0;
                o_state.linker_seen    = 1'b0;
            end
        end
    end

endmodule

### src/grapheme_cluster_boundary_detector_core.sv
// Grapheme cluster boundary detector: one codepoint's break properties per input beat,
// one break_before flag per output beat, in order. Sustained rate is one beat per cycle
// while the output side does not stall; a beat is captured in the input register and
// its flag reaches the result register at the next edge the output side can take it.
// The rule check and state update sit between those two registers; the state advances
// as each beat moves into the result register. Input stall rises only while both
// registers are full and the output side stalls. text_start forces a break and reseeds
// the state; after reset the state reads previous class Other with all chain flags clear.
module grapheme_cluster_boundary_detector_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [3:0] i_gcb_class,
    input  logic [1:0] i_conjunct_class,
    input  logic       i_is_pictographic,
    input  logic       i_text_start,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_break_before
);
    import gcbd_pkg::*;

    logic   r_in_valid;
    t_item  r_item;
    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   r_out_break;
    logic   n_break;
    logic   in_load;
    logic   out_free;
    logic   move;

    // Handshake
    assign out_free   = !r_out_valid || !i_out_stall;
    assign move       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_load    = i_in_valid && !o_in_stall;

    gcbd_rules u_rules (
        .i_item  (r_item),
        .i_state (r_state),
        .o_break (n_break),
        .o_state (n_state)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
        end else begin
            if (in_load) begin
                r_in_valid <= 1'b1;
            end else if (move) begin
                r_in_valid <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_item.gcb_class       <= i_gcb_class;
            r_item.conjunct_class  <= i_conjunct_class;
            r_item.is_pictographic <= i_is_pictographic;
            r_item.text_start      <= i_text_start;
        end
        if (move) begin
            r_out_break <= n_break;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_break_before = r_out_break;

endmodule

### src/gcbd_checker.sv
module gcbd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_break_before
);

    // A stalled result beat stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its flag
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_break_before))
        else $error("result flag changed while stalled");

    // Input stall only when the output side holds a blocked beat
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without output back-pressure");

    // Reset empties the result register
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind grapheme_cluster_boundary_detector_core gcbd_checker u_gcbd_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_in_stall        (o_in_stall),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_break_before    (o_break_before)
);
